@@ design/xeu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_pkg
// types, state codes and entity tables shared by the entity unescape stream
// ----------------------------------------------------------------------------
package xeu_pkg;

    localparam int UnitW    = 16;
    localparam int StateW   = 4;
    localparam int MaxBurst = 6;
    localparam int CountW   = 3;

    typedef struct packed {
        logic [UnitW-1:0] code_unit;
        logic             last_of_string;
    } in_item_t;

    typedef struct packed {
        logic [UnitW-1:0] out_unit;
        logic             out_last;
    } out_item_t;

    // results of one input item, entry 0 goes out first
    typedef struct packed {
        out_item_t [MaxBurst-1:0] units;
        logic [CountW-1:0]        count;
        logic [StateW-1:0]        next_state;
    } burst_t;

    // pending prefix codes
    localparam logic [StateW-1:0] StIdle = 4'd0;
    localparam logic [StateW-1:0] StAmp  = 4'd1;
    localparam logic [StateW-1:0] StQ    = 4'd2;
    localparam logic [StateW-1:0] StQu   = 4'd3;
    localparam logic [StateW-1:0] StQuo  = 4'd4;
    localparam logic [StateW-1:0] StQuot = 4'd5;
    localparam logic [StateW-1:0] StA    = 4'd6;
    localparam logic [StateW-1:0] StAp   = 4'd7;
    localparam logic [StateW-1:0] StApo  = 4'd8;
    localparam logic [StateW-1:0] StApos = 4'd9;
    localparam logic [StateW-1:0] StAm   = 4'd10;
    localparam logic [StateW-1:0] StAmp2 = 4'd11;
    localparam logic [StateW-1:0] StL    = 4'd12;
    localparam logic [StateW-1:0] StLt   = 4'd13;
    localparam logic [StateW-1:0] StG    = 4'd14;
    localparam logic [StateW-1:0] StGt   = 4'd15;

    localparam logic [UnitW-1:0] ChAmp   = {8'h00, "&"};
    localparam logic [UnitW-1:0] ChSemi  = {8'h00, ";"};
    localparam logic [UnitW-1:0] ChQuote = {8'h00, "\""};
    localparam logic [UnitW-1:0] ChApos  = {8'h00, "'"};
    localparam logic [UnitW-1:0] ChLt    = {8'h00, "<"};
    localparam logic [UnitW-1:0] ChGt    = {8'h00, ">"};
    localparam logic [UnitW-1:0] ChA     = {8'h00, "a"};
    localparam logic [UnitW-1:0] ChG     = {8'h00, "g"};
    localparam logic [UnitW-1:0] ChL     = {8'h00, "l"};
    localparam logic [UnitW-1:0] ChM     = {8'h00, "m"};
    localparam logic [UnitW-1:0] ChO     = {8'h00, "o"};
    localparam logic [UnitW-1:0] ChP     = {8'h00, "p"};
    localparam logic [UnitW-1:0] ChQ     = {8'h00, "q"};
    localparam logic [UnitW-1:0] ChS     = {8'h00, "s"};
    localparam logic [UnitW-1:0] ChT     = {8'h00, "t"};
    localparam logic [UnitW-1:0] ChU     = {8'h00, "u"};
    localparam logic [UnitW-1:0] ChNone  = '0;

    // number of buffered units of a pending prefix
    function automatic logic [CountW-1:0] prefix_len(input logic [StateW-1:0] st);
        logic [CountW-1:0] len;
        len = 3'd0;
        if (st == StAmp) begin
            len = 3'd1;
        end else if (st inside {StQ, StA, StL, StG}) begin
            len = 3'd2;
        end else if (st inside {StQu, StAp, StAm, StLt, StGt}) begin
            len = 3'd3;
        end else if (st inside {StQuo, StApo, StAmp2}) begin
            len = 3'd4;
        end else if (st inside {StQuot, StApos}) begin
            len = 3'd5;
        end
        return len;
    endfunction

    // buffered unit at a position of a pending prefix
    function automatic logic [UnitW-1:0] prefix_char(input logic [StateW-1:0] st,
                                                     input logic [CountW-1:0] pos);
        logic [UnitW-1:0] ch;
        ch = ChNone;
        case (pos)
            3'd0: begin
                ch = ChAmp;
            end
            3'd1: begin
                if (st inside {[StQ:StQuot]}) ch = ChQ;
                else if (st inside {[StA:StAmp2]}) ch = ChA;
                else if (st inside {StL, StLt}) ch = ChL;
                else if (st inside {StG, StGt}) ch = ChG;
            end
            3'd2: begin
                if (st inside {[StQu:StQuot]}) ch = ChU;
                else if (st inside {[StAp:StApos]}) ch = ChP;
                else if (st inside {StAm, StAmp2}) ch = ChM;
                else if (st inside {StLt, StGt}) ch = ChT;
            end
            3'd3: begin
                if (st inside {StQuo, StQuot, StApo, StApos}) ch = ChO;
                else if (st == StAmp2) ch = ChP;
            end
            3'd4: begin
                if (st == StQuot) ch = ChT;
                else if (st == StApos) ch = ChS;
            end
            default: begin
                ch = ChNone;
            end
        endcase
        return ch;
    endfunction

    // character a complete entity stands for, zero when incomplete
    function automatic logic [UnitW-1:0] decoded_char(input logic [StateW-1:0] st);
        logic [UnitW-1:0] ch;
        case (st)
            StQuot:  ch = ChQuote;
            StApos:  ch = ChApos;
            StAmp2:  ch = ChAmp;
            StLt:    ch = ChLt;
            StGt:    ch = ChGt;
            default: ch = ChNone;
        endcase
        return ch;
    endfunction

    // prefix extended by one unit, idle when no entity continues that way
    function automatic logic [StateW-1:0] next_state(input logic [StateW-1:0] st,
                                                     input logic [UnitW-1:0] c);
        logic [StateW-1:0] nx;
        nx = StIdle;
        case (st)
            StAmp: begin
                if (c == ChQ) nx = StQ;
                else if (c == ChA) nx = StA;
                else if (c == ChL) nx = StL;
                else if (c == ChG) nx = StG;
            end
            StQ:     if (c == ChU) nx = StQu;
            StQu:    if (c == ChO) nx = StQuo;
            StQuo:   if (c == ChT) nx = StQuot;
            StA: begin
                if (c == ChP) nx = StAp;
                else if (c == ChM) nx = StAm;
            end
            StAp:    if (c == ChO) nx = StApo;
            StApo:   if (c == ChS) nx = StApos;
            StAm:    if (c == ChP) nx = StAmp2;
            StL:     if (c == ChT) nx = StLt;
            StG:     if (c == ChT) nx = StGt;
            default: nx = StIdle;
        endcase
        return nx;
    endfunction

endpackage
`default_nettype wire

@@ design/xeu_decode.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_decode
// builds the result burst and next prefix state for one code unit
// ----------------------------------------------------------------------------
module xeu_decode (
    input  wire logic [xeu_pkg::StateW-1:0] state,
    input  wire xeu_pkg::in_item_t          item,
    output xeu_pkg::burst_t                 burst
);
    import xeu_pkg::*;

    logic [UnitW-1:0]  code;
    logic [UnitW-1:0]  dec;
    logic [StateW-1:0] child;
    logic [StateW-1:0] st_a;
    logic [StateW-1:0] st_b;
    logic [StateW-1:0] st_mid;
    logic              single;
    logic [UnitW-1:0]  single_unit;
    logic [CountW-1:0] len_a;
    logic [CountW-1:0] len_b;
    logic [CountW-1:0] cnt;
    logic [CountW-1:0] pos;

    always_comb begin
        code        = item.code_unit;
        dec         = decoded_char(state);
        child       = next_state(state, code);
        st_a        = StIdle;
        st_mid      = StIdle;
        single      = 1'b0;
        single_unit = code;

        if (state != StIdle && code == ChSemi && dec != ChNone) begin
            // complete entity
            single      = 1'b1;
            single_unit = dec;
        end else if (state != StIdle && child != StIdle) begin
            st_mid = child;
        end else begin
            // prefix broken: flush it, then treat the unit as plain text, or as a new prefix if it is '&'
            st_a = state;
            if (code == ChAmp) begin
                st_mid = StAmp;
            end else begin
                single = 1'b1;
            end
        end

        // end of string flushes what is still pending
        if (item.last_of_string) begin
            st_b             = st_mid;
            burst.next_state = StIdle;
        end else begin
            st_b             = StIdle;
            burst.next_state = st_mid;
        end

        len_a = prefix_len(st_a);
        len_b = prefix_len(st_b);
        cnt   = len_a + {2'b00, single} + len_b;
        burst.count = cnt;

        for (int k = 0; k < MaxBurst; k++) begin
            pos = CountW'(k);
            if (pos < len_a) begin
                burst.units[k].out_unit = prefix_char(st_a, pos);
            end else if (single && pos == len_a) begin
                burst.units[k].out_unit = single_unit;
            end else begin
                burst.units[k].out_unit = prefix_char(st_b, pos - len_a - {2'b00, single});
            end
            burst.units[k].out_last = item.last_of_string && (pos == cnt - 3'd1);
        end
    end

endmodule
`default_nettype wire

@@ design/xml_entity_unescape_stream_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xml_entity_unescape_stream_unit
// streaming decoder for the five predefined xml entities
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one utf-16 code unit per transfer, last_of_string marks the
//   final unit of a string. m_ channel: one unescaped code unit per transfer,
//   out_last on the final unit of a string.
//   an input transfer lands in an input register; from there it is decoded
//   into a burst of 0 to 6 results that loads a burst register once it is
//   free; the burst register drains one result per cycle while m_ready is high.
//   throughput: one input transfer per cycle while each item yields at most
//   one result and m_ready is high; an item yielding more results holds the
//   input side until the single drain port of the burst register empties it.
//   a pending prefix (up to "&quot" or "&apos") yields no output until it
//   completes, fails or the string ends.
//   reset clears the prefix state, the input valid flag and the burst count.
//   when the receiver stalls, the burst holds, then the input register fills
//   and s_ready falls; nothing is dropped.
// ----------------------------------------------------------------------------
module xml_entity_unescape_stream_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire xeu_pkg::in_item_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output xeu_pkg::out_item_t       m_data
);
    import xeu_pkg::*;

    // input register
    in_item_t                 in_reg;
    logic                     in_valid_reg;
    logic                     in_valid_next;

    // prefix match state
    logic [StateW-1:0]        state_reg;
    logic [StateW-1:0]        state_next;

    // burst register, entry 0 is the head on the m_ side
    out_item_t [MaxBurst-1:0] burst_reg;
    out_item_t [MaxBurst-1:0] burst_next;
    logic [CountW-1:0]        rem_reg;
    logic [CountW-1:0]        rem_next;

    burst_t                   dec_burst;
    logic                     take;
    logic                     burst_free;
    logic                     in_move;

    xeu_decode u_decode (
        .state (state_reg),
        .item  (in_reg),
        .burst (dec_burst)
    );

    assign m_valid    = (rem_reg != '0);
    assign m_data     = burst_reg[0];
    assign take       = m_valid && m_ready;
    // burst register is free when empty or once its last entry leaves this cycle
    assign burst_free = (rem_reg == '0) || (rem_reg == 3'd1 && m_ready);
    assign in_move    = in_valid_reg && burst_free;
    assign s_ready    = !in_valid_reg || in_move;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (in_move) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        burst_next = burst_reg;
        rem_next   = rem_reg;
        if (in_move) begin
            // fresh burst from the decoder, possibly empty
            state_next = dec_burst.next_state;
            burst_next = dec_burst.units;
            rem_next   = dec_burst.count;
        end else if (take) begin
            // shift toward the head
            for (int k = 0; k < MaxBurst - 1; k++) begin
                burst_next[k] = burst_reg[k+1];
            end
            rem_next = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= StIdle;
            rem_reg      <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
            rem_reg      <= rem_next;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        burst_reg <= burst_next;
    end

    // burst never holds more results than one item can cause
    assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg <= CountW'(MaxBurst))
        else $error("burst count out of range");

    // end of string always leaves the prefix state idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_move && in_reg.last_of_string |=> state_reg == StIdle)
        else $error("prefix pending after end of string");

    // a blocked input item stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !burst_free |=> in_valid_reg && $stable(in_reg))
        else $error("input register lost while burst busy");

    // an end of string item always produces results with the last flag at the tail; this checks that there are results
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_move && in_reg.last_of_string |=> rem_reg != '0)
        else $error("end of string produced no result");

endmodule
`default_nettype wire
